>>> rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the K-way merge engine: field widths, the
// operation codes, the per-cell command and the candidate passed along the
// compare chain.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned LIST_IDX_W = 3;
  localparam int unsigned VALUE_W    = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_PULL  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;     // append data to the targeted list
    logic clear;    // empty all lists
    logic advance;  // step the targeted list past its head
    logic refill;   // data carries the targeted list's new head
  } cell_cmd_t;

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] value;
  } cand_t;

endpackage

>>> rtl/core/kwm_if.sv
// ----------------------------------------------------------------------------
// kwm_if
// Valid/ready channels of the K-way merge engine: the command channel and
// the result channel.
// ----------------------------------------------------------------------------
interface kwm_in_if import kwm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [OPCODE_W-1:0]          opcode;
  logic [LIST_IDX_W-1:0]        list_index;
  logic signed [VALUE_W-1:0]    value;

  modport source (output valid, output opcode, output list_index, output value,
                  input ready);
  modport sink   (input valid, input opcode, input list_index, input value,
                  output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_W-1:0]    merged_value;
  logic                         last;
  logic                         empty_res;

  modport source (output valid, output merged_value, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input merged_value, input last, input empty_res,
                  output ready);
endinterface

>>> rtl/core/kwm_cell.sv
// ----------------------------------------------------------------------------
// kwm_cell
// One list of the merge engine: its length, read position and cached head,
// plus one registered stage of the minimum compare chain.
// ----------------------------------------------------------------------------
module kwm_cell import kwm_pkg::*; #(
  parameter int unsigned IDX_W    = 3,
  parameter int unsigned LEN_W    = 9,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_cmd_t                 cmd_i,
  input  logic [IDX_W-1:0]          tgt_i,
  input  logic signed [VALUE_W-1:0] data_i,
  input  cand_t                     cand_i,
  input  logic [IDX_W-1:0]          cand_idx_i,
  output cand_t                     cand_o,
  output logic [IDX_W-1:0]          cand_idx_o,
  output logic [LEN_W-1:0]          len_o,
  output logic [LEN_W-1:0]          pos_o
);

  logic [LEN_W-1:0]          len_q, len_d;
  logic [LEN_W-1:0]          pos_q, pos_d;
  logic signed [VALUE_W-1:0] head_q;
  cand_t                     cand_q, cand_d;
  logic [IDX_W-1:0]          cand_idx_q, cand_idx_d;
  logic                      hit;
  logic                      has_head;
  logic                      take;

  assign hit      = (tgt_i == IDX_W'(CELL_IDX));
  assign has_head = (pos_q != len_q);
  // Strict compare keeps the lower-numbered list on equal heads.
  assign take     = has_head && (!cand_i.found || (head_q < cand_i.value));

  always_comb begin
    len_d = len_q;
    pos_d = pos_q;
    if (cmd_i.clear) begin
      len_d = '0;
      pos_d = '0;
    end else begin
      if (cmd_i.load && hit) begin
        len_d = len_q + LEN_W'(1);
      end
      if (cmd_i.advance && hit) begin
        pos_d = pos_q + LEN_W'(1);
      end
    end
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.value = head_q;
      cand_idx_d   = IDX_W'(CELL_IDX);
    end else begin
      cand_d     = cand_i;
      cand_idx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pos_q      <= '0;
      cand_q     <= '0;
      cand_idx_q <= '0;
    end else begin
      len_q      <= len_d;
      pos_q      <= pos_d;
      cand_q     <= cand_d;
      cand_idx_q <= cand_idx_d;
    end
  end

  // A load into an empty list becomes the head at once; otherwise the head
  // is reloaded from the element store after an advance.
  always_ff @(posedge clk_i) begin
    if ((cmd_i.load && hit && !has_head) || (cmd_i.refill && hit)) begin
      head_q <= data_i;
    end
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = cand_idx_q;
  assign len_o      = len_q;
  assign pos_o      = pos_q;

  a_pos_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= len_q)
    else $error("read position passed list length");

  a_advance_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.advance && hit) |-> has_head)
    else $error("advance of an exhausted list");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (len_q == '0) && (pos_q == '0))
    else $error("clear did not empty the list");

endmodule

>>> rtl/core/k_way_merge_engine.sv
// ----------------------------------------------------------------------------
// k_way_merge_engine
// K-way merge of signed lists: load, pull-smallest-head and clear commands.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_i as valid/ready transactions. A load appends
// value to list list_index (dropped when the list is full or the index is out
// of range), a clear empties every list, and a pull returns one transaction on
// out_o with the smallest current head, a last flag when that element was the
// final one held, or empty_res when nothing was left.
// Loads and clears do not leave the idle state. A pull keeps in_i busy
// through the sweep and finish states, and through the refill state when the
// chosen list holds a further element. The running minimum walks down a row
// of NUM_LISTS registered cells, one cell per cycle. The finish state then
// commits the result, and the refill state reloads the chosen list's head
// from the element store. The result enters the output register at the
// commit, which waits while out_o still holds a result not yet taken.
// The output register decouples the receiver: loads and clears keep flowing
// while a result waits; a second pull holds its commit until out_o is free.
// Reset empties all lists and drops any pending result. The element store
// itself is not cleared; only entries written since the last clear are read.
// ----------------------------------------------------------------------------
module k_way_merge_engine import kwm_pkg::*; #(
  parameter int unsigned NUM_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwm_in_if.sink    in_i,
  kwm_out_if.source out_o
);

  localparam int unsigned IDX_W     = $clog2(NUM_LISTS);
  localparam int unsigned LEN_W     = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned RC_W      = $clog2(MEM_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH,
    ST_REFILL
  } state_e;

  state_e                    state_q;
  logic [IDX_W-1:0]          sweep_cnt_q;
  logic [RC_W-1:0]           remaining_q;
  logic [IDX_W-1:0]          refill_idx_q;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last_q;
  logic                      out_empty_q;

  // Element store, one region of LIST_DEPTH entries per list.
  logic signed [VALUE_W-1:0] mem_q [MEM_DEPTH];
  logic signed [VALUE_W-1:0] rdata_q;

  // Compare chain and per-list status from the cells.
  cand_t            chain     [NUM_LISTS+1];
  logic [IDX_W-1:0] chain_idx [NUM_LISTS+1];
  logic [LEN_W-1:0] len_a     [NUM_LISTS];
  logic [LEN_W-1:0] pos_a     [NUM_LISTS];

  cell_cmd_t                 cmd;
  logic [IDX_W-1:0]          tgt;
  logic signed [VALUE_W-1:0] cell_data;
  logic                      in_fire;
  logic                      in_range;
  logic [IDX_W-1:0]          tgt_in;
  logic [LEN_W-1:0]          len_in;
  logic                      load_ok;
  logic                      commit;
  cand_t                     best;
  logic [IDX_W-1:0]          best_idx;
  logic [LEN_W-1:0]          pos_sel;
  logic [LEN_W-1:0]          len_sel;
  logic                      more;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Decode of the incoming command; index range is checked at full width so
  // that any list count works.
  assign in_range = (32'(in_i.list_index) < 32'(NUM_LISTS));
  assign tgt_in   = IDX_W'(32'(in_i.list_index));
  assign len_in   = len_a[tgt_in];
  assign load_ok  = in_fire && (in_i.opcode == OP_LOAD) && in_range
                    && (len_in < LEN_W'(LIST_DEPTH));

  // The last cell holds the minimum once the sweep has run its length.
  assign best     = chain[NUM_LISTS];
  assign best_idx = chain_idx[NUM_LISTS];
  assign pos_sel  = pos_a[best_idx];
  assign len_sel  = len_a[best_idx];
  assign more     = (pos_sel + LEN_W'(1)) < len_sel;
  assign commit   = !out_valid_q || out_o.ready;

  always_comb begin
    cmd.load    = load_ok;
    cmd.clear   = in_fire && (in_i.opcode == OP_CLEAR);
    cmd.advance = (state_q == ST_FINISH) && commit && best.found;
    cmd.refill  = (state_q == ST_REFILL);
    unique case (state_q)
      ST_FINISH: tgt = best_idx;
      ST_REFILL: tgt = refill_idx_q;
      default:   tgt = tgt_in;
    endcase
    cell_data = (state_q == ST_REFILL) ? rdata_q : in_i.value;
  end

  assign chain[0]     = '0;
  assign chain_idx[0] = '0;

  for (genvar k = 0; k < NUM_LISTS; k++) begin : g_cell
    kwm_cell #(
      .IDX_W    (IDX_W),
      .LEN_W    (LEN_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .tgt_i      (tgt),
      .data_i     (cell_data),
      .cand_i     (chain[k]),
      .cand_idx_i (chain_idx[k]),
      .cand_o     (chain[k+1]),
      .cand_idx_o (chain_idx[k+1]),
      .len_o      (len_a[k]),
      .pos_o      (pos_a[k])
    );
  end

  // Store write on a load, store read of the next element, if any, on an advance.
  assign wr_en   = load_ok;
  assign wr_addr = ADDR_W'(32'(tgt_in) * LIST_DEPTH + 32'(len_in));
  assign rd_en   = cmd.advance && more;
  assign rd_addr = ADDR_W'(32'(best_idx) * LIST_DEPTH + 32'(pos_sel) + 32'd1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer with the remaining count and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sweep_cnt_q  <= '0;
      remaining_q  <= '0;
      refill_idx_q <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
      out_empty_q  <= 1'b0;
    end else begin
      // In the finish state the commit below owns the valid flag.
      if (out_valid_q && out_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (load_ok) begin
            remaining_q <= remaining_q + RC_W'(1);
          end
          if (cmd.clear) begin
            remaining_q <= '0;
          end
          if (in_fire && (in_i.opcode == OP_PULL)) begin
            sweep_cnt_q <= '0;
            state_q     <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          sweep_cnt_q <= sweep_cnt_q + IDX_W'(1);
          if (sweep_cnt_q == IDX_W'(NUM_LISTS - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            if (best.found) begin
              out_value_q  <= best.value;
              out_last_q   <= (remaining_q <= RC_W'(1));
              out_empty_q  <= 1'b0;
              refill_idx_q <= best_idx;
              if (remaining_q != '0) begin
                remaining_q <= remaining_q - RC_W'(1);
              end
              state_q <= more ? ST_REFILL : ST_IDLE;
            end else begin
              out_value_q <= '0;
              out_last_q  <= 1'b0;
              out_empty_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        ST_REFILL: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_value_q;
  assign out_o.last         = out_last_q;
  assign out_o.empty_res    = out_empty_q;

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> ((out_value_q == '0) && !out_last_q))
    else $error("empty result carries a value or last flag");

  a_nothing_found_none_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && !best.found) |-> (remaining_q == '0))
    else $error("no head found while elements remain");

  a_pull_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.advance |=> (remaining_q == $past(remaining_q) - RC_W'(1)))
    else $error("remaining count not stepped on a pull");

endmodule
